FILE: sv/udpf_pkg.sv
// Shared types and constants for the UDP receive filter.
`default_nettype none

package udpf_pkg;

    localparam int MAX_FRAME = 2048;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE = 2'd2;
    localparam logic [1:0] KIND_TRUNC    = 2'd3;

    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_LOCAL_PORT  = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd2048;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [15:0] datagram_length;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/udpf_parse.sv
// Frame header parser: tracks byte position, checks headers, yields at most one result per word.
`default_nettype none

module udpf_parse (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 accept,
    input  wire [7:0]           frame_byte,
    input  wire                 frame_end,
    input  udpf_pkg::cfg_t      cfg,
    output logic                res_valid,
    output udpf_pkg::result_t   res
);
    import udpf_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DISCARD = 2'd2;

    localparam logic [POS_W-1:0] P_ETH_HI  = POS_W'(12);
    localparam logic [POS_W-1:0] P_ETH_LO  = POS_W'(13);
    localparam logic [POS_W-1:0] P_PROTO   = POS_W'(23);
    localparam logic [POS_W-1:0] P_SIP_0   = POS_W'(26);
    localparam logic [POS_W-1:0] P_SIP_3   = POS_W'(29);
    localparam logic [POS_W-1:0] P_DIP_0   = POS_W'(30);
    localparam logic [POS_W-1:0] P_DIP_1   = POS_W'(31);
    localparam logic [POS_W-1:0] P_DIP_2   = POS_W'(32);
    localparam logic [POS_W-1:0] P_DIP_3   = POS_W'(33);
    localparam logic [POS_W-1:0] P_SPORT_0 = POS_W'(34);
    localparam logic [POS_W-1:0] P_SPORT_1 = POS_W'(35);
    localparam logic [POS_W-1:0] P_DPORT_0 = POS_W'(36);
    localparam logic [POS_W-1:0] P_DPORT_1 = POS_W'(37);
    localparam logic [POS_W-1:0] P_LEN_0   = POS_W'(38);
    localparam logic [POS_W-1:0] P_LEN_1   = POS_W'(39);
    localparam logic [POS_W-1:0] P_LAST    = POS_W'(41);
    localparam logic [POS_W-1:0] P_MAX     = POS_W'(MAX_FRAME);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       phase_reg, phase_next;
    logic             match_reg, match_next;
    logic [31:0]      sip_reg, sip_next;
    logic [15:0]      sport_reg, sport_next;
    logic [15:0]      ulen_reg, ulen_next;
    logic [15:0]      remain_reg, remain_next;

    logic             in_frame;
    logic [7:0]       ref_byte;
    logic             ref_chk;
    logic [15:0]      plen;
    logic [15:0]      remain_dec;

    assign in_frame   = pos_reg < P_MAX;
    assign plen       = ulen_reg - UDP_HDR_LEN;
    assign remain_dec = remain_reg - 16'd1;

    // expected byte for the positions compared against constants or config
    always_comb begin
        ref_chk  = 1'b1;
        ref_byte = 8'd0;
        case (pos_reg)
            P_ETH_HI:  ref_byte = ETHERTYPE_IPV4[15:8];
            P_ETH_LO:  ref_byte = ETHERTYPE_IPV4[7:0];
            P_PROTO:   ref_byte = PROTO_UDP;
            P_DIP_0:   ref_byte = cfg.local_ip[31:24];
            P_DIP_1:   ref_byte = cfg.local_ip[23:16];
            P_DIP_2:   ref_byte = cfg.local_ip[15:8];
            P_DIP_3:   ref_byte = cfg.local_ip[7:0];
            P_DPORT_0: ref_byte = cfg.local_port[15:8];
            P_DPORT_1: ref_byte = cfg.local_port[7:0];
            default:   ref_chk  = 1'b0;
        endcase
    end

    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        match_next  = match_reg;
        sip_next    = sip_reg;
        sport_next  = sport_reg;
        ulen_next   = ulen_reg;
        remain_next = remain_reg;
        res_valid   = 1'b0;
        res.kind            = KIND_DATA;
        res.payload_byte    = 8'd0;
        res.payload_last    = 1'b1;
        res.sender_ip       = sip_reg;
        res.sender_port     = sport_reg;
        res.datagram_length = plen;

        if (accept) begin
            if (in_frame) begin
                pos_next = pos_reg + POS_W'(1);
            end
            case (phase_reg)
                PH_HEADER: begin
                    if (ref_chk && ref_byte != frame_byte) begin
                        match_next = 1'b0;
                    end
                    if (pos_reg >= P_SIP_0 && pos_reg <= P_SIP_3) begin
                        sip_next = {sip_reg[23:0], frame_byte};
                    end
                    if (pos_reg == P_SPORT_0 || pos_reg == P_SPORT_1) begin
                        sport_next = {sport_reg[7:0], frame_byte};
                    end
                    if (pos_reg == P_LEN_0 || pos_reg == P_LEN_1) begin
                        ulen_next = {ulen_reg[7:0], frame_byte};
                    end
                    if (pos_reg == P_LAST) begin
                        phase_next = PH_DISCARD;
                        if (match_reg) begin
                            if (ulen_reg < UDP_HDR_LEN || plen > cfg.max_payload) begin
                                res_valid = 1'b1;
                                res.kind  = KIND_OVERSIZE;
                            end else if (ulen_reg == UDP_HDR_LEN) begin
                                res_valid = 1'b1;
                                res.kind  = KIND_EMPTY;
                            end else begin
                                remain_next = plen;
                                if (frame_end) begin
                                    res_valid = 1'b1;
                                    res.kind  = KIND_TRUNC;
                                end else begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (in_frame) begin
                        remain_next      = remain_dec;
                        res_valid        = 1'b1;
                        res.payload_byte = frame_byte;
                        if (remain_dec == 16'd0) begin
                            phase_next = PH_DISCARD;
                        end else if (frame_end) begin
                            res.kind = KIND_TRUNC;
                        end else begin
                            res.payload_last = 1'b0;
                        end
                    end else if (frame_end) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_TRUNC;
                    end
                end
                default: ;
            endcase
            if (frame_end) begin
                pos_next   = '0;
                phase_next = PH_HEADER;
                match_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            phase_reg  <= PH_HEADER;
            match_reg  <= 1'b1;
            sip_reg    <= '0;
            sport_reg  <= '0;
            ulen_reg   <= '0;
            remain_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            sip_reg    <= sip_next;
            sport_reg  <= sport_next;
            ulen_reg   <= ulen_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/udp_receive_filter.sv
// Top level of the UDP receive filter: config registers, parser and output buffer.
// Each result is registered in the output stage, or in the skid entry while the output word is held.
// One frame word per cycle while s_ready is high; s_ready drops while the skid entry is full.
// A two-entry output buffer keeps s_ready high while one result waits on m_ready.
// Reset (aresetn low, synchronous) clears position, phase and buffer valids and
// returns the config registers to their defaults (max_payload 2048, others 0).
`default_nettype none

module udp_receive_filter (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_frame_byte,
    input  wire         s_frame_end,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_last,
    output logic [31:0] m_sender_ip,
    output logic [15:0] m_sender_port,
    output logic [15:0] m_datagram_length
);
    import udpf_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    pop;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.local_ip    <= '0;
            cfg_reg.local_port  <= '0;
            cfg_reg.max_payload <= MAX_PAYLOAD_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LOCAL_IP:    cfg_reg.local_ip    <= pwdata;
                REG_LOCAL_PORT:  cfg_reg.local_port  <= pwdata[15:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOCAL_IP:    prdata = cfg_reg.local_ip;
            REG_LOCAL_PORT:  prdata = {16'd0, cfg_reg.local_port};
            REG_MAX_PAYLOAD: prdata = {16'd0, cfg_reg.max_payload};
            default:         prdata = 32'd0;
        endcase
    end

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    udpf_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .frame_byte (s_frame_byte),
        .frame_end  (s_frame_end),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // skid entry is only filled while the output word is held, and drains first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= res_valid;
            out_reg       <= res;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
            skid_reg       <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = out_reg.kind;
    assign m_payload_byte    = out_reg.payload_byte;
    assign m_payload_last    = out_reg.payload_last;
    assign m_sender_ip       = out_reg.sender_ip;
    assign m_sender_port     = out_reg.sender_port;
    assign m_datagram_length = out_reg.datagram_length;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output stage");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled output word lost or changed");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.kind != KIND_DATA) |-> out_reg.payload_last)
        else $error("status word without last mark");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (!skid_valid_reg && out_valid_reg && !m_ready && res_valid) |=> skid_valid_reg)
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: tb/tb_udp_receive_filter.sv
// Self-checking testbench for the UDP receive filter: directed frame table, then random frames.
`timescale 1ns / 1ps

module tb_udp_receive_filter;
    import udpf_pkg::*;

    typedef enum bit [1:0] {ST_HEADER, ST_BODY, ST_SKIP} rx_stage_t;

    typedef struct {
        bit [15:0]   ethertype;
        bit [7:0]    proto;
        bit [31:0]   src_ip;
        bit [31:0]   dst_ip;
        bit [15:0]   src_port;
        bit [15:0]   dst_port;
        bit [15:0]   udp_len;
        int unsigned frame_len;
    } frame_t;

    // One directed frame; where 'typed' is set the result is given here, not predicted.
    typedef struct packed {
        bit [1:0]  cfg_sel;
        bit [15:0] ethertype;
        bit [7:0]  proto;
        bit [31:0] dst_ip;
        bit [15:0] dst_port;
        bit [15:0] udp_len;
        bit [15:0] frame_len;
        bit        typed;
        bit        typed_out;
        bit [1:0]  typed_kind;
    } dir_row_t;

    localparam int N_DIR       = 22;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_WORDS = 200;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_valid      = 1'b0;
    wire         s_ready;
    logic [7:0]  s_frame_byte = '0;
    logic        s_frame_end  = 1'b0;
    wire         m_valid;
    logic        m_ready      = 1'b0;
    wire  [1:0]  m_kind;
    wire  [7:0]  m_payload_byte;
    wire         m_payload_last;
    wire  [31:0] m_sender_ip;
    wire  [15:0] m_sender_port;
    wire  [15:0] m_datagram_length;

    udp_receive_filter u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_byte      (s_frame_byte),
        .s_frame_end       (s_frame_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_payload_byte    (m_payload_byte),
        .m_payload_last    (m_payload_last),
        .m_sender_ip       (m_sender_ip),
        .m_sender_port     (m_sender_port),
        .m_datagram_length (m_datagram_length)
    );

    // Filter state as the block should hold it
    cfg_t             cur_cfg     = {32'h0, 16'h0, MAX_PAYLOAD_RST};
    bit [POS_W-1:0]   rx_pos      = '0;
    rx_stage_t        rx_stage    = ST_HEADER;
    bit               hdr_ok      = 1'b1;
    bit [31:0]        src_ip_cap  = '0;
    bit [15:0]        src_port_cap = '0;
    bit [15:0]        udp_len_cap = '0;
    bit [15:0]        bytes_left  = '0;

    result_t          pending_results[$];
    dir_row_t         dir_tab [N_DIR];
    cfg_t             cfg_tab [3];
    int               mismatches     = 0;
    int unsigned      words_sent     = 0;
    int unsigned      src_gap_pct    = 0;
    int unsigned      sink_stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("udp_receive_filter regression: fail");
        $finish;
    end

    // Advance the filter by one frame byte; returns 1 when a result is due.
    function automatic bit filter_byte(input bit [7:0] b, input bit e, output result_t r);
        bit [POS_W-1:0] p;
        bit             in_frame;
        bit             got;
        p        = rx_pos;
        in_frame = (p < POS_W'(MAX_FRAME));
        got      = 1'b0;
        r        = '0;
        r.payload_last = 1'b1;
        if (in_frame)
            rx_pos = p + POS_W'(1);
        case (rx_stage)
            ST_HEADER: begin
                if (p == 12 && b != ETHERTYPE_IPV4[15:8]) hdr_ok = 1'b0;
                if (p == 13 && b != ETHERTYPE_IPV4[7:0]) hdr_ok = 1'b0;
                if (p == 23 && b != PROTO_UDP) hdr_ok = 1'b0;
                if (p >= 26 && p <= 29) src_ip_cap = {src_ip_cap[23:0], b};
                if (p >= 30 && p <= 33 && cur_cfg.local_ip[8*(33-p) +: 8] != b) hdr_ok = 1'b0;
                if (p == 34 || p == 35) src_port_cap = {src_port_cap[7:0], b};
                if (p == 36 && b != cur_cfg.local_port[15:8]) hdr_ok = 1'b0;
                if (p == 37 && b != cur_cfg.local_port[7:0]) hdr_ok = 1'b0;
                if (p == 38 || p == 39) udp_len_cap = {udp_len_cap[7:0], b};
                if (p == 41) begin
                    rx_stage = ST_SKIP;
                    if (hdr_ok) begin
                        if (udp_len_cap < UDP_HDR_LEN ||
                            udp_len_cap - UDP_HDR_LEN > cur_cfg.max_payload) begin
                            r.kind = KIND_OVERSIZE;
                            got    = 1'b1;
                        end else if (udp_len_cap == UDP_HDR_LEN) begin
                            r.kind = KIND_EMPTY;
                            got    = 1'b1;
                        end else begin
                            bytes_left = udp_len_cap - UDP_HDR_LEN;
                            if (e) begin
                                r.kind = KIND_TRUNC;
                                got    = 1'b1;
                            end else begin
                                rx_stage = ST_BODY;
                            end
                        end
                    end
                end
            end
            ST_BODY: begin
                if (in_frame) begin
                    bytes_left     = bytes_left - 16'd1;
                    got            = 1'b1;
                    r.payload_byte = b;
                    if (bytes_left == 0) begin
                        r.kind   = KIND_DATA;
                        rx_stage = ST_SKIP;
                    end else if (e) begin
                        r.kind = KIND_TRUNC;
                    end else begin
                        r.kind         = KIND_DATA;
                        r.payload_last = 1'b0;
                    end
                end else if (e) begin
                    // past the frame limit only the end mark counts
                    r.kind = KIND_TRUNC;
                    got    = 1'b1;
                end
            end
            default: ;
        endcase
        r.sender_ip       = src_ip_cap;
        r.sender_port     = src_port_cap;
        r.datagram_length = udp_len_cap - UDP_HDR_LEN;
        if (e) begin
            rx_pos   = '0;
            rx_stage = ST_HEADER;
            hdr_ok   = 1'b1;
        end
        return got;
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatches++;
        end
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Junk in the unused upper bits of the 16-bit registers must be dropped
    task automatic set_config(input cfg_t c);
        apb_write(REG_LOCAL_IP, c.local_ip);
        cur_cfg.local_ip = c.local_ip;
        apb_write(REG_LOCAL_PORT, {16'($urandom), c.local_port});
        cur_cfg.local_port = c.local_port;
        apb_write(REG_MAX_PAYLOAD, {16'($urandom), c.max_payload});
        cur_cfg.max_payload = c.max_payload;
    endtask

    // Stop sending and let every outstanding result drain before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic drive_frame(input frame_t f, input bit typed, input bit typed_out,
                               input bit [1:0] typed_kind);
        bit [7:0]    hdr [0:41];
        bit [7:0]    b;
        bit          e;
        result_t     r;
        int unsigned i;
        foreach (hdr[k]) hdr[k] = 8'($urandom);
        {hdr[12], hdr[13]}                 = f.ethertype;
        hdr[14]                            = 8'h45;
        {hdr[16], hdr[17]}                 = f.udp_len + 16'd20;
        hdr[23]                            = f.proto;
        {hdr[26], hdr[27], hdr[28], hdr[29]} = f.src_ip;
        {hdr[30], hdr[31], hdr[32], hdr[33]} = f.dst_ip;
        {hdr[34], hdr[35]}                 = f.src_port;
        {hdr[36], hdr[37]}                 = f.dst_port;
        {hdr[38], hdr[39]}                 = f.udp_len;
        if (typed && typed_out) begin
            r                 = '0;
            r.kind            = typed_kind;
            r.payload_last    = 1'b1;
            r.sender_ip       = f.src_ip;
            r.sender_port     = f.src_port;
            r.datagram_length = f.udp_len - UDP_HDR_LEN;
            pending_results.push_back(r);
        end
        for (i = 0; i < f.frame_len; i++) begin
            if (i < 42)
                b = hdr[i];
            else
                b = 8'($urandom);
            e = (i == f.frame_len - 1);
            if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while ($urandom_range(99) < src_gap_pct) @(posedge aclk);
            end
            s_valid      <= 1'b1;
            s_frame_byte <= b;
            s_frame_end  <= e;
            do @(posedge aclk); while (!s_ready);
            words_sent++;
            if (filter_byte(b, e, r) && !typed)
                pending_results.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: kind %0d byte %0h", m_kind, m_payload_byte);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                cmp_field("kind", 32'(want.kind), 32'(m_kind));
                cmp_field("payload_byte", 32'(want.payload_byte), 32'(m_payload_byte));
                cmp_field("payload_last", 32'(want.payload_last), 32'(m_payload_last));
                cmp_field("sender_ip", want.sender_ip, m_sender_ip);
                cmp_field("sender_port", 32'(want.sender_port), 32'(m_sender_port));
                cmp_field("datagram_length", 32'(want.datagram_length),
                          32'(m_datagram_length));
            end
        end
    end

    initial begin : stimulus
        frame_t      f;
        dir_row_t    row;
        cfg_t        c;
        bit [1:0]    cfg_now;
        int          ph;
        int unsigned pick;
        int unsigned plen;
        int unsigned phase_start;

        cfg_tab[0] = {32'h0000_0000, 16'h0000, MAX_PAYLOAD_RST};
        cfg_tab[1] = {32'hFFFF_FFFF, 16'hFFFF, 16'h0000};
        cfg_tab[2] = {32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
        dir_tab = '{
            // reset settings: address 0, port 0, max payload 2048
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd12,   16'd46,   1'b0, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd8,    16'd42,   1'b1, 1'b1, KIND_EMPTY},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd7,    16'd50,   1'b1, 1'b1, KIND_OVERSIZE},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd0,    16'd42,   1'b1, 1'b1, KIND_OVERSIZE},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd2056, 16'd60,   1'b0, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd2057, 16'd60,   1'b1, 1'b1, KIND_OVERSIZE},
            // headers cut short
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd12,   16'd41,   1'b1, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd12,   16'd1,    1'b1, 1'b0, KIND_DATA},
            // filtered out
            '{2'd0, 16'h86DD,       PROTO_UDP, 32'h0, 16'h0, 16'd12,   16'd46,   1'b1, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, 8'd6,      32'h0, 16'h0, 16'd12,   16'd46,   1'b1, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h1, 16'h0, 16'd12,   16'd46,   1'b1, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h8000, 16'd12, 16'd46,  1'b1, 1'b0, KIND_DATA},
            // frame ends on the last header byte, then mid-payload, then after the payload with padding
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd20,   16'd42,   1'b1, 1'b1, KIND_TRUNC},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd20,   16'd50,   1'b0, 1'b0, KIND_DATA},
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd10,   16'd64,   1'b0, 1'b0, KIND_DATA},
            // payload runs past the frame limit
            '{2'd0, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0, 16'd2048, 16'd2050, 1'b0, 1'b0, KIND_DATA},
            // all-ones address and port, max payload 0
            '{2'd1, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 16'd8, 16'd42, 1'b1, 1'b1,
              KIND_EMPTY},
            '{2'd1, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 16'd9, 16'd43, 1'b1, 1'b1,
              KIND_OVERSIZE},
            '{2'd1, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFE, 16'hFFFF, 16'd9, 16'd43, 1'b1, 1'b0,
              KIND_DATA},
            // max payload all ones
            '{2'd2, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd60, 1'b0,
              1'b0, KIND_DATA},
            '{2'd2, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 16'd9, 16'd43, 1'b0, 1'b0,
              KIND_DATA},
            '{2'd2, ETHERTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 16'd14, 16'd48, 1'b0, 1'b0,
              KIND_DATA}
        };
        cfg_now = 2'd0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[n]) begin
            row = dir_tab[n];
            if (row.cfg_sel != cfg_now) begin
                settle();
                set_config(cfg_tab[row.cfg_sel]);
                cfg_now = row.cfg_sel;
            end
            f.ethertype = row.ethertype;
            f.proto     = row.proto;
            f.src_ip    = $urandom;
            f.dst_ip    = row.dst_ip;
            f.src_port  = 16'($urandom);
            f.dst_port  = row.dst_port;
            f.udp_len   = row.udp_len;
            f.frame_len = row.frame_len;
            drive_frame(f, row.typed, row.typed_out, row.typed_kind);
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 46; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 46; end
                default: begin src_gap_pct = 9; sink_stall_pct = 9; end
            endcase
            c.local_ip   = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
            c.local_port = (ph == 0) ? 16'h0 : (ph == 1) ? 16'hFFFF : 16'($urandom);
            case (ph)
                0:       c.max_payload = 16'h0000;
                1:       c.max_payload = 16'hFFFF;
                2:       c.max_payload = MAX_PAYLOAD_RST;
                default: c.max_payload = 16'($urandom_range(40, 4));
            endcase
            set_config(c);

            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                pick        = $urandom_range(99);
                f.ethertype = ETHERTYPE_IPV4;
                f.proto     = PROTO_UDP;
                f.src_ip    = $urandom;
                f.src_port  = 16'($urandom);
                f.dst_ip    = cur_cfg.local_ip;
                f.dst_port  = cur_cfg.local_port;
                plen        = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(20);
                f.udp_len   = 16'(plen + 8);
                f.frame_len = 42 + plen;
                if (pick < 60) begin
                    // well-formed, sometimes with padding
                    if ($urandom_range(3) == 0)
                        f.frame_len += $urandom_range(8, 1);
                end else if (pick < 70) begin
                    f.frame_len = 42 + $urandom_range(plen);
                end else if (pick < 78) begin
                    f.udp_len = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom);
                end else if (pick < 90) begin
                    case ($urandom_range(3))
                        0:       f.ethertype ^= 16'h1 << $urandom_range(15);
                        1:       f.proto     ^= 8'h1 << $urandom_range(7);
                        2:       f.dst_ip    ^= 32'h1 << $urandom_range(31);
                        default: f.dst_port  ^= 16'h1 << $urandom_range(15);
                    endcase
                end else if (pick < 95) begin
                    f.frame_len = $urandom_range(41, 1);
                end else begin
                    f.ethertype = 16'($urandom);
                    f.proto     = 8'($urandom);
                    f.dst_ip    = $urandom;
                    f.dst_port  = 16'($urandom);
                    f.udp_len   = 16'($urandom);
                    f.frame_len = $urandom_range(80, 1);
                end
                drive_frame(f, 1'b0, 1'b0, KIND_DATA);
            end
        end

        settle();
        if (mismatches == 0)
            $display("udp_receive_filter regression: pass");
        else
            $display("udp_receive_filter regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/udpf_pkg.sv
sv/udpf_parse.sv
sv/udp_receive_filter.sv
tb/tb_udp_receive_filter.sv
